FILE: src/midi_track_note_extractor_assert.svh
// Assertion macros shared by the checker of the note extractor.
`ifndef MIDI_TRACK_NOTE_EXTRACTOR_ASSERT_SVH
`define MIDI_TRACK_NOTE_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked on aclk outside reset.
`define MTNE_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("note extractor assertion failed");

// Next-cycle implication, checked on aclk outside reset.
`define MTNE_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("note extractor assertion failed");

`endif

FILE: src/mtne_pkg.sv
// Shared types and constants of the MIDI track note extractor.
package mtne_pkg;

    localparam int TimeBits   = 32;
    localparam int LenBits    = 28;
    localparam int PitchBits  = 7;
    localparam int QueueDepth = 4;
    localparam int QueuePtrBits = $clog2(QueueDepth);

    localparam logic [1:0] KIND_NOTE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_NOTE_ON,
        OP_NOTE_OFF,
        OP_END,
        OP_ERROR
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [PitchBits-1:0] pitch;
        logic [6:0]           velocity;
        logic [TimeBits-1:0]  ticks;
    } cmd_t;

endpackage

FILE: src/mtne_front.sv
// Byte parser: delta times, running status, meta and sysex skipping.
module mtne_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           byte_valid,
    output logic           byte_ready,
    input  logic [7:0]     track_byte,
    input  logic           track_start,
    input  logic [3:0]     selected_channel,
    output logic           cmd_valid,
    input  logic           cmd_ready,
    output mtne_pkg::cmd_t cmd
);
    import mtne_pkg::*;

    typedef enum logic [3:0] {
        PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META, PH_LEN, PH_SKIP
    } phase_t;

    localparam logic [7:0] META_END = 8'd47;

    phase_t              phase_reg, phase_next;
    logic [LenBits-1:0]  len_reg, len_next;
    logic [TimeBits-1:0] clock_reg, clock_next;
    logic [7:0]          status_reg, status_next;
    logic [6:0]          data1_reg, data1_next;
    logic [LenBits-1:0]  skip_reg, skip_next;
    logic [7:0]          meta_reg, meta_next;
    logic                done_reg, done_next;

    logic               accept;
    logic               emit;
    logic [LenBits-1:0] len_shift;
    logic [LenBits-1:0] skip_dec;
    logic [3:0]         hi;

    assign byte_ready = cmd_ready;
    assign accept     = byte_valid && byte_ready;
    assign cmd_valid  = accept && emit;

    always_comb begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        clock_next  = clock_reg;
        status_next = status_reg;
        data1_next  = data1_reg;
        skip_next   = skip_reg;
        meta_next   = meta_reg;
        done_next   = done_reg;
        emit        = 1'b0;
        cmd         = '{op: OP_ERROR, pitch: '0, velocity: '0, ticks: '0};
        if (track_start) begin
            phase_next  = PH_DELTA;
            len_next    = '0;
            clock_next  = '0;
            status_next = '0;
            data1_next  = '0;
            skip_next   = '0;
            meta_next   = '0;
            done_next   = 1'b0;
            emit        = 1'b1;
            cmd.op      = OP_CLEAR;
        end
        len_shift = {len_next[LenBits-8:0], track_byte[6:0]};
        skip_dec  = (skip_next != '0) ? skip_next - 1'b1 : skip_next;
        hi        = status_next[7:4];
        if (!done_next) begin
            unique case (phase_next)
                PH_DELTA: begin
                    len_next = len_shift;
                    if (!track_byte[7]) begin
                        clock_next = clock_next + TimeBits'(len_shift);
                        len_next   = '0;
                        phase_next = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (!track_byte[7]) begin
                        if (status_next == '0) begin
                            phase_next = PH_DELTA;
                            len_next   = '0;
                            emit       = 1'b1;
                            cmd.op     = OP_ERROR;
                        end else begin
                            data1_next = track_byte[6:0];
                            phase_next = (hi == 4'hC || hi == 4'hD) ? PH_DELTA : PH_DATA2;
                        end
                    end else if (track_byte < 8'hF0) begin
                        status_next = track_byte;
                        phase_next  = PH_DATA1;
                    end else if (track_byte == 8'hFF) begin
                        status_next = '0;
                        phase_next  = PH_META;
                    end else if (track_byte == 8'hF0 || track_byte == 8'hF7) begin
                        status_next = '0;
                        meta_next   = track_byte;
                        len_next    = '0;
                        phase_next  = PH_LEN;
                    end else begin
                        phase_next = PH_DELTA;
                        len_next   = '0;
                        emit       = 1'b1;
                        cmd.op     = OP_ERROR;
                    end
                end
                PH_DATA1: begin
                    if (track_byte[7]) begin
                        phase_next = PH_DELTA;
                        len_next   = '0;
                        emit       = 1'b1;
                        cmd.op     = OP_ERROR;
                    end else begin
                        data1_next = track_byte[6:0];
                        phase_next = (hi == 4'hC || hi == 4'hD) ? PH_DELTA : PH_DATA2;
                    end
                end
                PH_DATA2: begin
                    phase_next = PH_DELTA;
                    if (track_byte[7]) begin
                        len_next = '0;
                        emit     = 1'b1;
                        cmd.op   = OP_ERROR;
                    end else if (status_next[3:0] == selected_channel) begin
                        cmd.pitch    = data1_next;
                        cmd.velocity = track_byte[6:0];
                        cmd.ticks    = clock_next;
                        if (hi == 4'h9 && track_byte[6:0] != '0) begin
                            emit   = 1'b1;
                            cmd.op = OP_NOTE_ON;
                        end else if (hi == 4'h8 || hi == 4'h9) begin
                            emit   = 1'b1;
                            cmd.op = OP_NOTE_OFF;
                        end
                    end
                end
                PH_META: begin
                    meta_next  = track_byte;
                    len_next   = '0;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    len_next = len_shift;
                    if (!track_byte[7]) begin
                        skip_next = len_shift;
                        len_next  = '0;
                        if (len_shift == '0) begin
                            phase_next = PH_DELTA;
                            if (meta_next == META_END) begin
                                done_next = 1'b1;
                                emit      = 1'b1;
                                cmd.op    = OP_END;
                            end
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == '0) begin
                        phase_next = PH_DELTA;
                        if (meta_next == META_END) begin
                            done_next = 1'b1;
                            emit      = 1'b1;
                            cmd.op    = OP_END;
                        end
                    end
                end
                default: phase_next = PH_DELTA;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_DELTA;
            len_reg    <= '0;
            clock_reg  <= '0;
            status_reg <= '0;
            data1_reg  <= '0;
            skip_reg   <= '0;
            meta_reg   <= '0;
            done_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            clock_reg  <= clock_next;
            status_reg <= status_next;
            data1_reg  <= data1_next;
            skip_reg   <= skip_next;
            meta_reg   <= meta_next;
            done_reg   <= done_next;
        end
    end

endmodule

FILE: src/mtne_queue.sv
// Short command queue between the parser and the note table.
module mtne_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  mtne_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output mtne_pkg::cmd_t out_cmd
);
    import mtne_pkg::*;

    cmd_t                  slot_reg [QueueDepth];
    logic [QueuePtrBits-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QueuePtrBits:0]   count_reg;
    logic push, pop;

    assign in_ready  = count_reg != (QueuePtrBits+1)'(QueueDepth);
    assign out_valid = count_reg != '0;
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= in_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: src/mtne_back.sv
// Note table: pairs note-on and note-off commands and drives the result word.
module mtne_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  mtne_pkg::cmd_t cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     out_kind,
    output logic [79:0]    out_data
);
    import mtne_pkg::*;

    localparam int Pitches = 2 ** PitchBits;
    localparam int EntryBits = TimeBits + 7;

    logic [EntryBits-1:0] mem [Pitches];
    logic [Pitches-1:0]   active_reg;
    logic [EntryBits-1:0] rd_reg, byp_data_reg;
    logic                 byp_reg;
    cmd_t                 b_cmd_reg;
    logic                 b_valid_reg;
    logic                 out_valid_reg;
    logic [1:0]           kind_reg;
    logic [79:0]          data_reg;

    logic                 adv, take, b_fire, b_write, b_emit, hit;
    logic [EntryBits-1:0] entry, wdata;
    logic [1:0]           kind_next;
    logic [79:0]          data_next;

    assign adv       = !out_valid_reg || out_ready;
    assign cmd_ready = adv;
    assign take      = adv && cmd_valid;
    assign b_fire    = adv && b_valid_reg;
    assign entry     = byp_reg ? byp_data_reg : rd_reg;
    assign hit       = active_reg[b_cmd_reg.pitch];
    assign b_write   = b_cmd_reg.op == OP_NOTE_ON;
    assign wdata     = {b_cmd_reg.velocity, b_cmd_reg.ticks};

    always_comb begin
        b_emit    = 1'b0;
        kind_next = KIND_NOTE;
        data_next = '0;
        unique case (b_cmd_reg.op)
            OP_NOTE_ON, OP_NOTE_OFF: begin
                b_emit    = hit;
                data_next = {2'b00, entry[EntryBits-1:TimeBits], b_cmd_reg.pitch,
                             b_cmd_reg.ticks, entry[TimeBits-1:0]};
            end
            OP_END: begin
                b_emit    = 1'b1;
                kind_next = KIND_END;
            end
            OP_ERROR: begin
                b_emit    = 1'b1;
                kind_next = KIND_ERROR;
            end
            default: b_emit = 1'b0;
        endcase
    end

    // Read at the edge the command enters the stage; the entry written on the
    // same edge is forwarded.
    always_ff @(posedge aclk) begin
        if (take) begin
            rd_reg       <= mem[cmd.pitch];
            byp_reg      <= b_fire && b_write && (cmd.pitch == b_cmd_reg.pitch);
            byp_data_reg <= wdata;
            b_cmd_reg    <= cmd;
        end
        if (b_fire && b_write) mem[b_cmd_reg.pitch] <= wdata;
        if (adv) begin
            kind_reg <= kind_next;
            data_reg <= data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                b_valid_reg   <= cmd_valid;
                out_valid_reg <= b_fire && b_emit;
            end
            if (b_fire) begin
                case (b_cmd_reg.op)
                    OP_CLEAR:    active_reg <= '0;
                    OP_NOTE_ON:  active_reg[b_cmd_reg.pitch] <= 1'b1;
                    OP_NOTE_OFF: active_reg[b_cmd_reg.pitch] <= 1'b0;
                    default:     active_reg <= active_reg;
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = kind_reg;
    assign out_data  = data_reg;

endmodule

FILE: src/midi_track_note_extractor.sv
// Top level of the MIDI track note extractor.
//  channel | direction | carries
//  s_      | in        | one track byte per word, tuser = track start
//  m_      | out       | one result per word, tuser = kind
//  cfg_    | in        | selected channel write
// One byte per cycle sustained while the command queue has room; the note table
// read-modify-write is pipelined with forwarding, so same-pitch events may follow each other.
// Results pass through a four-word command queue, the registered note table read
// stage and the registered output word before they appear on m_.
// Synchronous active-low reset clears parser state and the note table valid bits.
// A stalled output holds its word and backs up into the queue, then s_tready.
module midi_track_note_extractor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // track_byte[7:0]
    input  logic        s_tuser,   // track_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // onset[31:0], offset[63:32], pitch[70:64],
                                   // velocity[77:71], zero[79:78]
    output logic [1:0]  m_tuser,   // kind[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data   // selected_channel[3:0]
);
    import mtne_pkg::*;

    logic [3:0] channel_reg;
    logic       f_valid, f_ready, q_valid, q_ready;
    cmd_t       f_cmd, q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) channel_reg <= '0;
        else if (cfg_valid) channel_reg <= cfg_data;
    end

    mtne_front u_front (
        .aclk, .aresetn,
        .byte_valid(s_tvalid), .byte_ready(s_tready),
        .track_byte(s_tdata), .track_start(s_tuser),
        .selected_channel(channel_reg),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    mtne_queue u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    mtne_back u_back (
        .aclk, .aresetn,
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_kind(m_tuser), .out_data(m_tdata)
    );

endmodule

FILE: src/mtne_checker.sv
// Port-level checker of the note extractor and its bind.
`include "midi_track_note_extractor_assert.svh"

module mtne_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import mtne_pkg::*;

    // hold a stalled result word
    `MTNE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `MTNE_ASSERT_NOW(a_kind, m_tvalid, m_tuser == KIND_NOTE || m_tuser == KIND_END || m_tuser == KIND_ERROR)
    `MTNE_ASSERT_NOW(a_zero, m_tvalid && m_tuser != KIND_NOTE, m_tdata == 80'd0)
    `MTNE_ASSERT_NOW(a_vel, m_tvalid && m_tuser == KIND_NOTE, m_tdata[77:71] != 7'd0)
endmodule

bind midi_track_note_extractor mtne_checker u_checker (.*);

FILE: tb/sv/tb_midi_track_note_extractor.sv
// Self-checking testbench of the MIDI track note extractor: byte stream in, notes out.
module tb_midi_track_note_extractor;
    import mtne_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam logic [2:0] PH_DELTA = 3'd0, PH_STATUS = 3'd1, PH_DATA1 = 3'd2,
        PH_DATA2 = 3'd3, PH_META = 3'd4, PH_LEN = 3'd5, PH_SKIP = 3'd6;
    localparam logic [7:0] ST_OFF = 8'h80, ST_ON = 8'h90, ST_SYSEX = 8'hF0,
        ST_ESC = 8'hF7, ST_META = 8'hFF, META_EOT = 8'h2F;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] onset;
        logic [31:0] offset;
        logic [6:0]  pitch;
        logic [6:0]  vel;
    } note_rec_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } track_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = '0;

    midi_track_note_extractor uut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state
    logic [3:0]  chan_sel;
    logic [2:0]  phase;
    logic [27:0] vlq_acc;
    logic [31:0] tick_clk;
    logic [7:0]  run_stat;
    logic [6:0]  data1;
    logic [27:0] skip_left;
    logic [7:0]  meta_id;
    logic        done;
    logic [31:0] note_onset [128];
    logic [6:0]  note_vel [128];

    track_word_t byte_q[$];
    note_rec_t   note_q[$];
    int          errors = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_off = 1'b0;
    bit          in_fire = 1'b0;
    int          quiet = 0;

    function automatic note_rec_t mk(logic [1:0] k, logic [31:0] on = 0,
                                     logic [31:0] off = 0, logic [6:0] p = 0,
                                     logic [6:0] v = 0);
        note_rec_t r;
        r.kind = k; r.onset = on; r.offset = off; r.pitch = p; r.vel = v;
        return r;
    endfunction

    task automatic clear_parse();
        phase = PH_DELTA; vlq_acc = 0; tick_clk = 0; run_stat = 0; data1 = 0;
        skip_left = 0; meta_id = 0; done = 0;
        for (int i = 0; i < 128; i++) begin
            note_vel[i] = 0; note_onset[i] = 0;
        end
    endtask

    task automatic parse_error();
        phase = PH_DELTA; vlq_acc = 0;
        note_q.push_back(mk(KIND_ERROR));
    endtask

    task automatic end_skip();
        phase = PH_DELTA;
        if (meta_id == META_EOT) begin
            done = 1;
            note_q.push_back(mk(KIND_END));
        end
    endtask

    task automatic first_data(logic [7:0] b);
        data1 = b[6:0];
        phase = (run_stat[7:4] == 4'hC || run_stat[7:4] == 4'hD) ? PH_DELTA : PH_DATA2;
    endtask

    task automatic predict_byte(track_word_t w);
        logic [7:0] b;
        b = w.data;
        if (w.start) clear_parse();
        if (done) return;
        case (phase)
            PH_DELTA: begin
                vlq_acc = {vlq_acc[20:0], b[6:0]};
                if (!b[7]) begin
                    tick_clk += vlq_acc; vlq_acc = 0; phase = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (!b[7]) begin
                    if (run_stat == 0) parse_error();
                    else first_data(b);
                end else if (b < ST_SYSEX) begin
                    run_stat = b; phase = PH_DATA1;
                end else if (b == ST_META) begin
                    run_stat = 0; phase = PH_META;
                end else if (b == ST_SYSEX || b == ST_ESC) begin
                    run_stat = 0; meta_id = b; vlq_acc = 0; phase = PH_LEN;
                end else parse_error();
            end
            PH_DATA1: if (b[7]) parse_error(); else first_data(b);
            PH_DATA2: begin
                if (b[7]) parse_error();
                else begin
                    phase = PH_DELTA;
                    if (run_stat[3:0] == chan_sel) begin
                        if (run_stat[7:4] == ST_ON[7:4] && b != 0) begin
                            if (note_vel[data1] != 0)
                                note_q.push_back(mk(KIND_NOTE, note_onset[data1], tick_clk,
                                                    data1, note_vel[data1]));
                            note_vel[data1] = b[6:0]; note_onset[data1] = tick_clk;
                        end else if (run_stat[7:4] == ST_OFF[7:4] ||
                                     run_stat[7:4] == ST_ON[7:4]) begin
                            if (note_vel[data1] != 0) begin
                                note_q.push_back(mk(KIND_NOTE, note_onset[data1], tick_clk,
                                                    data1, note_vel[data1]));
                                note_vel[data1] = 0;
                            end
                        end
                    end
                end
            end
            PH_META: begin
                meta_id = b; vlq_acc = 0; phase = PH_LEN;
            end
            PH_LEN: begin
                vlq_acc = {vlq_acc[20:0], b[6:0]};
                if (!b[7]) begin
                    skip_left = vlq_acc; vlq_acc = 0;
                    if (skip_left == 0) end_skip();
                    else phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (skip_left != 0) skip_left--;
                if (skip_left == 0) end_skip();
            end
            default: phase = PH_DELTA;
        endcase
    endtask

    // driver: one word per handshake, inputs move on the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || in_fire) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    s_tvalid <= 1'b1;
                    {s_tdata, s_tuser} <= byte_q[0];
                    predict_byte(byte_q.pop_front());
                end else s_tvalid <= 1'b0;
            end
            m_tready <= !hold_off && $urandom_range(99) >= stall_pct;
        end
    end

    // monitor
    always @(posedge aclk) begin
        note_rec_t got, want;
        in_fire <= s_tvalid && s_tready;
        if (aresetn) begin
            quiet <= (s_tvalid && s_tready) || (m_tvalid && m_tready) ? 0 : quiet + 1;
            if (quiet > STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got = mk(m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[70:64],
                         m_tdata[77:71]);
                if (note_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected word %h", got);
                end else begin
                    want = note_q.pop_front();
                    if (got !== want || m_tdata[79:78] !== 2'b00) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %h got %h", want, got);
                    end
                end
            end
        end
    end

    function automatic int vlq_push(int n);
        // push n as a variable-length number, MSB group first
        logic [6:0] g [4];
        int cnt;
        cnt = 0;
        do begin
            g[cnt] = n[6:0]; n = n >> 7; cnt++;
        end while (n != 0 && cnt < 4);
        for (int i = cnt - 1; i >= 0; i--)
            byte_q.push_back('{data: {i != 0, g[i]}, start: 1'b0});
        return cnt;
    endfunction

    task automatic put(logic [7:0] b, logic st = 1'b0);
        byte_q.push_back('{data: b, start: st});
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || s_tvalid || note_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_channel(logic [3:0] c);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= c;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        chan_sel = c;
    endtask

    // one random event, mostly well formed
    task automatic random_event(logic [3:0] ch);
        int r, d;
        logic [7:0] st;
        r = $urandom_range(99);
        if (r < 50) d = $urandom_range(3); else if (r < 90) d = $urandom_range(200);
        else d = $urandom;
        void'(vlq_push(d));
        r = $urandom_range(99);
        if (r < 70) begin
            st = ($urandom_range(3) == 0) ? {4'($urandom_range(8, 14)), 4'($urandom)}
                                          : {($urandom_range(1) ? ST_ON[7:4] : ST_OFF[7:4]),
                                             ($urandom_range(4) == 0 ? 4'($urandom) : ch)};
            if ($urandom_range(3) != 0) put(st);
            put(8'($urandom_range(60, 67)));
            if (st[7:4] != 4'hC && st[7:4] != 4'hD)
                put($urandom_range(3) == 0 ? 8'h00 : 8'($urandom_range(127)));
        end else if (r < 80) begin
            put($urandom_range(1) ? ST_META : 8'(ST_SYSEX | ($urandom_range(1) ? 7 : 0)));
            if (byte_q[$].data == ST_META) put($urandom_range(9) == 0 ? META_EOT : 8'h01);
            d = $urandom_range(4);
            void'(vlq_push(d));
            repeat (d) put(8'($urandom));
        end else put(8'($urandom));
    endtask

    initial begin
        int n;
        clear_parse();
        chan_sel = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: note pairs, retrigger, zero-velocity off, bend, metas, errors
        put(8'h00, 1'b1); put(8'h90); put(8'h00); put(8'h7F);
        put(8'h81); put(8'h00); put(8'h00); put(8'h7F); put(8'h01);
        put(8'h00); put(8'h90); put(8'h00); put(8'h40);
        put(8'h05); put(8'h00); put(8'h00);
        put(8'h00); put(8'h80); put(8'h7F); put(8'h00);
        put(8'h00); put(8'hE0); put(8'h01); put(8'h02);
        put(8'h00); put(8'hF1); put(8'h00); put(8'h90); put(8'h90);
        put(8'h00, 1'b1); put(8'h45);
        put(8'hFF); put(8'hFF); put(8'hFF); put(8'hFF); put(8'h7F);
        put(8'hC0); put(8'h05);
        put(8'h00); put(8'hFF); put(8'h2F); put(8'h00); put(8'h99);
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            write_channel(ph == 0 ? 4'd15 : ph == 1 ? 4'd0 : 4'($urandom));
            case (ph)
                1: idle_pct = 56;
                2: begin idle_pct = 0; stall_pct = 56; end
                3: begin idle_pct = 24; stall_pct = 24; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            n = 0;
            put(8'h00, 1'b1);
            while (n < 55) begin
                random_event(chan_sel);
                n++;
                if ($urandom_range(150) == 0) put(8'h00, 1'b1);
            end
            if (ph == 4) begin
                hold_off = 1'b1;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            wait_drained();
        end

        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule

FILE: midi_track_note_extractor.f
+incdir+src
src/mtne_pkg.sv
src/mtne_front.sv
src/mtne_queue.sv
src/mtne_back.sv
src/midi_track_note_extractor.sv
src/mtne_checker.sv
tb/sv/tb_midi_track_note_extractor.sv
